FILE: rtl/core/cst_pkg.sv
`timescale 1ns / 1ps
package cst_pkg;

	// Text offsets clip here (the smaller of the text size less one and the offset range).
	localparam int unsigned TEXT_MAX_BYTES = 65536;
	localparam logic [15:0] POS_LIMIT      = (TEXT_MAX_BYTES - 1 > 65535) ? 16'hFFFF
	                                         : 16'(TEXT_MAX_BYTES - 1);
	localparam logic [30:0] VALUE_MAX      = 31'h7FFF_FFFF;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	localparam logic [3:0] KIND_SIGN   = 4'd0;
	localparam logic [3:0] KIND_IDENT  = 4'd1;
	localparam logic [3:0] KIND_NUM    = 4'd2;
	localparam logic [3:0] KIND_RETURN = 4'd3;
	localparam logic [3:0] KIND_IF     = 4'd4;
	localparam logic [3:0] KIND_ELSE   = 4'd5;
	localparam logic [3:0] KIND_WHILE  = 4'd6;
	localparam logic [3:0] KIND_FOR    = 4'd7;
	localparam logic [3:0] KIND_END    = 4'd8;
	localparam logic [3:0] KIND_ERROR  = 4'd9;

	localparam logic [3:0] SIGN_GE   = 4'd0;
	localparam logic [3:0] SIGN_LE   = 4'd1;
	localparam logic [3:0] SIGN_GT   = 4'd2;
	localparam logic [3:0] SIGN_LT   = 4'd3;
	localparam logic [3:0] SIGN_LPAR = 4'd4;
	localparam logic [3:0] SIGN_RPAR = 4'd5;
	localparam logic [3:0] SIGN_ADD  = 4'd6;
	localparam logic [3:0] SIGN_SUB  = 4'd7;
	localparam logic [3:0] SIGN_MUL  = 4'd8;
	localparam logic [3:0] SIGN_DIV  = 4'd9;
	localparam logic [3:0] SIGN_SEMI = 4'd10;
	localparam logic [3:0] SIGN_ASGN = 4'd11;

	// Keywords in kind order: return, if, else, while, for.
	localparam logic [0:4][0:5][7:0] KW_TEXT = '{
		"return",
		{"if", 32'd0},
		{"else", 16'd0},
		{"while", 8'd0},
		{"for", 24'd0}
	};
	localparam logic [0:4][2:0] KW_LEN = '{3'd6, 3'd2, 3'd4, 3'd5, 3'd3};

	typedef struct packed {
		logic [3:0]  kind;
		logic [3:0]  code;
		logic [15:0] start;
		logic [15:0] len;
		logic [30:0] val;
		logic        ovf;
	} tok_t;

	// One queue entry: the tokens a single byte gives, in order.
	typedef struct packed {
		logic a_v;
		tok_t a;
		logic b_v;
		tok_t b;
	} qent_t;

	typedef struct packed {
		logic hit;
		logic [3:0] code;
	} sign_hit_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic sign_hit_t sign_lookup(input logic [7:0] c);
		sign_hit_t r;
		r.hit  = 1'b1;
		r.code = SIGN_GE;
		unique case (c)
			"(": r.code = SIGN_LPAR;
			")": r.code = SIGN_RPAR;
			"+": r.code = SIGN_ADD;
			"-": r.code = SIGN_SUB;
			"*": r.code = SIGN_MUL;
			"/": r.code = SIGN_DIV;
			";": r.code = SIGN_SEMI;
			"=": r.code = SIGN_ASGN;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	// Keywords that still match with character c at offset idx of the run.
	function automatic logic [4:0] kw_keep(input logic [15:0] idx, input logic [7:0] c);
		logic [4:0] m;
		logic [2:0] i;
		i = (idx < 16'd6) ? idx[2:0] : 3'd0;
		for (int k = 0; k < 5; k++) begin
			m[k] = (idx < 16'(KW_LEN[k])) && (KW_TEXT[k][i] == c);
		end
		return m;
	endfunction

endpackage

FILE: rtl/core/cst_in_if.sv
`timescale 1ns / 1ps
interface cst_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_marker;

	modport source(output valid, text_byte, end_marker, input ready);
	modport sink(input valid, text_byte, end_marker, output ready);
endinterface

FILE: rtl/core/cst_out_if.sv
`timescale 1ns / 1ps
interface cst_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [3:0]  sign_code;
	logic [15:0] start_offset;
	logic [15:0] token_length;
	logic [30:0] number_value;
	logic        value_overflow;
	logic        last_of_item;

	modport source(output valid, token_kind, sign_code, start_offset, token_length,
		number_value, value_overflow, last_of_item, input ready);
	modport sink(input valid, token_kind, sign_code, start_offset, token_length,
		number_value, value_overflow, last_of_item, output ready);
endinterface

FILE: rtl/core/cst_front.sv
`timescale 1ns / 1ps
module cst_front import cst_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	cst_in_if.sink   text,
	input  logic     full,
	output logic     push,
	output qent_t    push_data
);

	localparam logic [2:0] MODE_IDLE  = 3'd0;
	localparam logic [2:0] MODE_IDENT = 3'd1;
	localparam logic [2:0] MODE_NUM   = 3'd2;
	localparam logic [2:0] MODE_GT    = 3'd3;
	localparam logic [2:0] MODE_LT    = 3'd4;
	localparam logic [2:0] MODE_ERR   = 3'd5;

	logic [2:0]  mode_q, mode_n;
	logic [15:0] pos_q, pos_n;
	logic [15:0] start_q, start_n;
	logic [30:0] acc_q, acc_n;
	logic        ovf_q, ovf_n;
	logic [4:0]  cand_q, cand_n;

	logic        take;
	logic [7:0]  c;
	logic [15:0] run_len;
	logic [34:0] acc_wide;
	tok_t        flush_tok;
	logic        flush_v;
	logic        consumed;
	logic        do_flush;
	sign_hit_t   sh;
	qent_t       ent;

	assign text.ready = !full;
	assign take       = text.valid && text.ready;
	assign c          = text.text_byte;
	assign run_len    = pos_q - start_q;
	assign sh         = sign_lookup(c);
	assign acc_wide   = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + 35'(c - 8'h30);

	// Token that closes the pending run, if any.
	always_comb begin
		flush_tok       = '0;
		flush_tok.start = start_q;
		flush_tok.len   = run_len;
		flush_v         = 1'b1;
		unique case (mode_q)
			MODE_IDENT: begin
				flush_tok.kind = KIND_IDENT;
				for (int k = 0; k < 5; k++) begin
					if (cand_q[k] && run_len == 16'(KW_LEN[k])) begin
						flush_tok.kind = KIND_RETURN + 4'(k);
					end
				end
			end
			MODE_NUM: begin
				flush_tok.kind = KIND_NUM;
				flush_tok.val  = acc_q;
				flush_tok.ovf  = ovf_q;
			end
			MODE_GT: begin
				flush_tok.code = SIGN_GT;
				flush_tok.len  = 16'd1;
			end
			MODE_LT: begin
				flush_tok.code = SIGN_LT;
				flush_tok.len  = 16'd1;
			end
			default: flush_v = 1'b0;
		endcase
	end

	always_comb begin
		mode_n   = mode_q;
		pos_n    = pos_q;
		start_n  = start_q;
		acc_n    = acc_q;
		ovf_n    = ovf_q;
		cand_n   = cand_q;
		ent      = '0;
		consumed = 1'b0;
		do_flush = 1'b0;

		if (text.end_marker) begin
			ent.a_v       = flush_v;
			ent.a         = flush_tok;
			ent.b_v       = (mode_q != MODE_ERR);
			ent.b.kind    = KIND_END;
			ent.b.start   = pos_q;
			mode_n        = MODE_IDLE;
			pos_n         = '0;
			start_n       = '0;
			acc_n         = '0;
			ovf_n         = 1'b0;
			cand_n        = 5'h1F;
		end else begin
			unique case (mode_q)
				MODE_IDENT: begin
					if (is_letter(c)) begin
						cand_n   = cand_q & kw_keep(run_len, c);
						consumed = 1'b1;
					end else begin
						do_flush = 1'b1;
					end
				end
				MODE_NUM: begin
					if (is_digit(c)) begin
						if (acc_wide > {4'd0, VALUE_MAX}) begin
							acc_n = VALUE_MAX;
							ovf_n = 1'b1;
						end else begin
							acc_n = acc_wide[30:0];
						end
						consumed = 1'b1;
					end else begin
						do_flush = 1'b1;
					end
				end
				MODE_GT, MODE_LT: begin
					if (c == "=") begin
						ent.a_v     = 1'b1;
						ent.a.kind  = KIND_SIGN;
						ent.a.code  = (mode_q == MODE_GT) ? SIGN_GE : SIGN_LE;
						ent.a.start = start_q;
						ent.a.len   = 16'd2;
						mode_n      = MODE_IDLE;
						consumed    = 1'b1;
					end else begin
						do_flush = 1'b1;
					end
				end
				MODE_ERR: consumed = 1'b1;
				default: ;
			endcase

			if (do_flush) begin
				ent.a_v = 1'b1;
				ent.a   = flush_tok;
				mode_n  = MODE_IDLE;
			end

			if (!consumed && !is_space(c)) begin
				start_n = pos_q;
				if (is_letter(c)) begin
					mode_n = MODE_IDENT;
					cand_n = kw_keep(16'd0, c);
				end else if (is_digit(c)) begin
					mode_n = MODE_NUM;
					acc_n  = 31'(c - 8'h30);
					ovf_n  = 1'b0;
				end else if (c == ">") begin
					mode_n = MODE_GT;
				end else if (c == "<") begin
					mode_n = MODE_LT;
				end else begin
					ent.b_v     = 1'b1;
					ent.b.start = pos_q;
					ent.b.len   = 16'd1;
					if (sh.hit) begin
						ent.b.kind = KIND_SIGN;
						ent.b.code = sh.code;
					end else begin
						ent.b.kind = KIND_ERROR;
						mode_n     = MODE_ERR;
					end
				end
			end

			if (pos_q < POS_LIMIT) begin
				pos_n = pos_q + 16'd1;
			end
		end
	end

	assign push      = take && (ent.a_v || ent.b_v);
	assign push_data = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pos_q   <= '0;
			start_q <= '0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			cand_q  <= 5'h1F;
		end else if (take) begin
			mode_q  <= mode_n;
			pos_q   <= pos_n;
			start_q <= start_n;
			acc_q   <= acc_n;
			ovf_q   <= ovf_n;
			cand_q  <= cand_n;
		end
	end

endmodule

FILE: rtl/core/cst_queue.sv
`timescale 1ns / 1ps
module cst_queue import cst_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_data,
	output logic  full,
	input  logic  pop,
	output qent_t head,
	output logic  empty
);

	qent_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (cnt_q == (QAW+1)'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/cst_back.sv
`timescale 1ns / 1ps
module cst_back import cst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  qent_t     head,
	input  logic      empty,
	output logic      pop,
	cst_out_if.source tokens
);

	tok_t tok_q;
	logic last_q;
	logic valid_q;
	logic sub_q;

	logic use_a;
	logic is_last;
	logic load;

	assign use_a   = head.a_v && !sub_q;
	assign is_last = !use_a || !head.b_v;
	assign load    = (!valid_q || tokens.ready) && !empty;
	assign pop     = load && is_last;

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q  <= use_a ? head.a : head.b;
			last_q <= is_last;
		end
	end

	// Send the first token of an entry, then the second if it has one, then drop the entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sub_q   <= !is_last;
			end else if (tokens.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign tokens.valid          = valid_q;
	assign tokens.token_kind     = tok_q.kind;
	assign tokens.sign_code      = tok_q.code;
	assign tokens.start_offset   = tok_q.start;
	assign tokens.token_length   = tok_q.len;
	assign tokens.number_value   = tok_q.val;
	assign tokens.value_overflow = tok_q.ovf;
	assign tokens.last_of_item   = last_q;

endmodule

FILE: rtl/core/c_subset_token_scanner.sv
`timescale 1ns / 1ps
// Channel  Role  Word
// text     sink  text_byte[7:0], end_marker
// tokens   src   token_kind, sign_code, start_offset, token_length,
//                number_value, value_overflow, last_of_item
//
// One text word is taken each cycle while the queue is not full; its tokens (none, one or
// two) pass through the queue and the output register, which sends one token per cycle
// while tokens.ready is high. A word giving two tokens holds the output for both; the
// four-entry queue between scanner and output absorbs this; text.ready falls only when it
// is full. Reset puts the scanner in its idle state at offset zero; no clearing pass.
module c_subset_token_scanner import cst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	cst_in_if.sink    text,
	cst_out_if.source tokens
);

	logic  push;
	qent_t push_data;
	logic  full;
	logic  pop;
	qent_t head;
	logic  empty;

	cst_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.full     (full),
		.push     (push),
		.push_data(push_data)
	);

	cst_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	cst_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.empty (empty),
		.pop   (pop),
		.tokens(tokens)
	);

endmodule

FILE: rtl/core/cst_checker.sv
`timescale 1ns / 1ps
module cst_checker import cst_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  kind,
	input logic [3:0]  code,
	input logic [15:0] len,
	input logic [30:0] val,
	input logic        ovf,
	input logic        last
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("token dropped while stalled");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(kind) && $stable(len) && $stable(last))
		else $error("token changed while stalled");

	a_value_only_num: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_NUM |-> val == '0 && !ovf)
		else $error("value on a non-number token");

	a_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_END |-> len == '0 && last)
		else $error("end token malformed");

	a_two_char_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_SIGN |->
		((len == 16'd2) == (code == SIGN_GE || code == SIGN_LE)))
		else $error("sign length does not match code");

endmodule

bind c_subset_token_scanner cst_checker u_cst_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(tokens.valid),
	.out_ready(tokens.ready),
	.kind     (tokens.token_kind),
	.code     (tokens.sign_code),
	.len      (tokens.token_length),
	.val      (tokens.number_value),
	.ovf      (tokens.value_overflow),
	.last     (tokens.last_of_item)
);
